// File: src/mbs_pkg.sv
// shared types, constants and pattern rom for the morse beeper sequencer
// used by the front, queue, sequencer and top-level modules; no dependencies
package mbs_pkg;

  localparam int FIFO_DEPTH = 32;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int DOT_W   = 10;
  localparam int TICK_W  = 14;
  localparam int LIM_W   = 13;
  localparam int SYM_W   = 6;
  localparam int ELEM_W  = 3;

  localparam logic [DOT_W-1:0]  DOT_RESET = 10'd50;
  localparam logic [TICK_W-1:0] TICK_MAX  = 14'h3FFF;

  // operation codes on the input channel
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // sequencer phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_MARK   = 3'd1;
  localparam logic [2:0] PH_GAP    = 3'd2;
  localparam logic [2:0] PH_LETTER = 3'd3;
  localparam logic [2:0] PH_WORD   = 3'd4;

  // symbol codes: letters 0..25, digits 26..35, then the word space
  localparam logic [SYM_W-1:0] SYM_COUNT = 6'd36;
  localparam logic [SYM_W-1:0] SYM_SPACE = 6'd36;

  typedef struct packed {
    logic             tick;
    logic             clear;
    logic             push;
    logic             known;
    logic [SYM_W-1:0] code;
  } front_ctl_t;

  typedef struct packed {
    logic             full;
    logic             has_known;
    logic [SYM_W-1:0] head_code;
  } q_stat_t;

  typedef struct packed {
    logic mark;
    logic active;
  } seq_stat_t;

  // queued symbol plus the unknown characters dropped in front of it
  typedef struct packed {
    logic [CNT_W-1:0] skip;
    logic [SYM_W-1:0] code;
  } q_entry_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // element count per symbol
  function automatic logic [ELEM_W-1:0] sym_len(input logic [SYM_W-1:0] s);
    case (s)
      6'd4, 6'd19:                                   sym_len = 3'd1;
      6'd0, 6'd8, 6'd12, 6'd13:                      sym_len = 3'd2;
      6'd3, 6'd6, 6'd10, 6'd14, 6'd17, 6'd18, 6'd20,
      6'd22:                                         sym_len = 3'd3;
      6'd1, 6'd2, 6'd5, 6'd7, 6'd9, 6'd11, 6'd15, 6'd16,
      6'd21, 6'd23, 6'd24, 6'd25:                    sym_len = 3'd4;
      6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
      6'd33, 6'd34, 6'd35:                           sym_len = 3'd5;
      default:                                       sym_len = 3'd0;
    endcase
  endfunction

  // bit i set: element i is a dash
  function automatic logic [7:0] sym_pat(input logic [SYM_W-1:0] s);
    case (s)
      6'd0:  sym_pat = 8'd2;   6'd1:  sym_pat = 8'd1;   6'd2:  sym_pat = 8'd5;
      6'd3:  sym_pat = 8'd1;   6'd4:  sym_pat = 8'd0;   6'd5:  sym_pat = 8'd4;
      6'd6:  sym_pat = 8'd3;   6'd7:  sym_pat = 8'd0;   6'd8:  sym_pat = 8'd0;
      6'd9:  sym_pat = 8'd14;  6'd10: sym_pat = 8'd5;   6'd11: sym_pat = 8'd2;
      6'd12: sym_pat = 8'd3;   6'd13: sym_pat = 8'd1;   6'd14: sym_pat = 8'd7;
      6'd15: sym_pat = 8'd6;   6'd16: sym_pat = 8'd11;  6'd17: sym_pat = 8'd2;
      6'd18: sym_pat = 8'd0;   6'd19: sym_pat = 8'd1;   6'd20: sym_pat = 8'd4;
      6'd21: sym_pat = 8'd8;   6'd22: sym_pat = 8'd6;   6'd23: sym_pat = 8'd9;
      6'd24: sym_pat = 8'd13;  6'd25: sym_pat = 8'd3;   6'd26: sym_pat = 8'd31;
      6'd27: sym_pat = 8'd30;  6'd28: sym_pat = 8'd28;  6'd29: sym_pat = 8'd24;
      6'd30: sym_pat = 8'd16;  6'd31: sym_pat = 8'd0;   6'd32: sym_pat = 8'd1;
      6'd33: sym_pat = 8'd3;   6'd34: sym_pat = 8'd7;   6'd35: sym_pat = 8'd15;
      default: sym_pat = 8'd0;
    endcase
  endfunction

endpackage

// File: src/mbs_front.sv
// front end: decodes the operation and classifies characters into symbol codes
// depends on mbs_pkg
module mbs_front
  import mbs_pkg::*;
(
  input  logic       accept,
  input  logic [1:0] op,
  input  logic [7:0] char_code,
  input  logic       full,
  output front_ctl_t ctl,
  output logic       overflow
);

  logic [7:0] folded;
  logic       wr;

  always_comb begin
    folded = char_code;
    if (char_code inside {[8'h61:8'h7A]}) begin
      folded = char_code - 8'd32;
    end
  end

  always_comb begin
    ctl       = '0;
    wr        = 1'b0;
    ctl.known = 1'b1;
    if (folded inside {[8'h30:8'h39]}) begin
      ctl.code = SYM_W'(folded - 8'h30) + 6'd26;
    end else if (folded inside {[8'h41:8'h5A]}) begin
      ctl.code = SYM_W'(folded - 8'h41);
    end else if (folded == 8'h20) begin
      ctl.code = SYM_SPACE;
    end else begin
      ctl.known = 1'b0;
    end
    if (accept) begin
      case (op)
        OP_TICK:  ctl.tick  = 1'b1;
        OP_WRITE: wr        = 1'b1;
        OP_STOP:  ctl.clear = 1'b1;
        default:  ;
      endcase
    end
    ctl.push = wr && !full;
    overflow = wr && full;
  end

endmodule

// File: src/mbs_symq.sv
// symbol queue between front and sequencer; unknown characters are only counted
// depends on mbs_pkg
module mbs_symq
  import mbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  front_ctl_t ctl,
  input  logic       fetch,
  output q_stat_t    stat,
  output logic       busy_next
);

  q_entry_t         mem [FIFO_DEPTH];
  q_entry_t         head;
  q_entry_t         wr_entry;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0] known_cnt, known_cnt_next;
  logic [CNT_W-1:0] total, total_next;
  logic [CNT_W-1:0] tail_unk, tail_unk_next;
  logic             push_known, push_unk, pop, drop;

  assign push_known = ctl.push && ctl.known;
  assign push_unk   = ctl.push && !ctl.known;
  assign pop        = fetch && (known_cnt != '0);
  assign drop       = fetch && (known_cnt == '0);
  assign wr_entry   = '{skip: tail_unk, code: ctl.code};

  always_comb begin
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    known_cnt_next = known_cnt;
    total_next     = total;
    tail_unk_next  = tail_unk;
    if (ctl.clear) begin
      rd_ptr_next    = '0;
      wr_ptr_next    = '0;
      known_cnt_next = '0;
      total_next     = '0;
      tail_unk_next  = '0;
    end else if (push_known) begin
      wr_ptr_next    = next_ptr(wr_ptr);
      known_cnt_next = known_cnt + 1'b1;
      total_next     = total + 1'b1;
      tail_unk_next  = '0;
    end else if (push_unk) begin
      total_next    = total + 1'b1;
      tail_unk_next = tail_unk + 1'b1;
    end else if (pop) begin
      rd_ptr_next    = next_ptr(rd_ptr);
      known_cnt_next = known_cnt - 1'b1;
      total_next     = total - head.skip - 1'b1;
    end else if (drop) begin
      // only unknown characters left: all go at once
      total_next    = '0;
      tail_unk_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      known_cnt <= '0;
      total     <= '0;
      tail_unk  <= '0;
    end else begin
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      known_cnt <= known_cnt_next;
      total     <= total_next;
      tail_unk  <= tail_unk_next;
    end
  end

  // head register always holds the entry at the read pointer
  always_ff @(posedge clk) begin
    if (push_known) begin
      mem[wr_ptr] <= wr_entry;
    end
    if (push_known && (wr_ptr == rd_ptr_next)) begin
      head <= wr_entry;
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

  assign stat.full      = (total == CNT_W'(FIFO_DEPTH));
  assign stat.has_known = (known_cnt != '0);
  assign stat.head_code = head.code;
  assign busy_next      = (total_next != '0);

endmodule

// File: src/mbs_seq.sv
// back end: tick-driven sequencer that keys the beeper from queued symbols
// depends on mbs_pkg
module mbs_seq
  import mbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [DOT_W-1:0] cfg_wdata,
  input  front_ctl_t       ctl,
  input  q_stat_t          qstat,
  output logic             fetch,
  output seq_stat_t        stat
);

  logic [DOT_W-1:0]  dot_ticks;
  logic [2:0]        phase, phase_next;
  logic [SYM_W-1:0]  symbol_index, symbol_index_next;
  logic [ELEM_W-1:0] element_index, element_index_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [TICK_W-1:0] tick_inc;
  logic [LIM_W-1:0]  d1, d3, d7, limit;
  logic [7:0]        pat;
  logic              sym_ok;

  assign d1     = LIM_W'(dot_ticks);
  assign d3     = d1 + {d1[LIM_W-2:0], 1'b0};
  assign d7     = {d1[LIM_W-4:0], 3'b000} - d1;
  assign sym_ok = (symbol_index < SYM_COUNT);
  assign pat    = sym_pat(symbol_index);
  assign tick_inc = (tick_count < TICK_MAX) ? tick_count + 1'b1 : tick_count;

  always_comb begin
    case (phase)
      PH_MARK:   limit = (sym_ok && pat[element_index]) ? d3 : d1;
      PH_GAP:    limit = d1;
      PH_LETTER: limit = d3;
      default:   limit = d7;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    symbol_index_next  = symbol_index;
    element_index_next = element_index;
    tick_count_next    = tick_count;
    fetch              = 1'b0;
    if (ctl.clear) begin
      phase_next         = PH_IDLE;
      symbol_index_next  = '0;
      element_index_next = '0;
      tick_count_next    = '0;
    end else if (ctl.tick) begin
      if (phase == PH_IDLE) begin
        fetch = 1'b1;
      end else if (tick_inc <= {1'b0, limit}) begin
        tick_count_next = tick_inc;
      end else begin
        tick_count_next = '0;
        case (phase)
          PH_MARK: begin
            phase_next = PH_GAP;
          end
          PH_GAP: begin
            element_index_next = element_index + 1'b1;
            if (sym_ok && (element_index_next < sym_len(symbol_index))) begin
              phase_next = PH_MARK;
            end else begin
              phase_next = PH_LETTER;
            end
          end
          default: begin
            fetch = 1'b1;
          end
        endcase
      end
    end
    if (fetch) begin
      tick_count_next = '0;
      if (!qstat.has_known) begin
        phase_next = PH_IDLE;
      end else if (qstat.head_code == SYM_SPACE) begin
        phase_next = PH_WORD;
      end else begin
        phase_next         = PH_MARK;
        symbol_index_next  = qstat.head_code;
        element_index_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks     <= DOT_RESET;
      phase         <= PH_IDLE;
      symbol_index  <= '0;
      element_index <= '0;
      tick_count    <= '0;
    end else begin
      if (cfg_we) begin
        dot_ticks <= cfg_wdata;
      end
      phase         <= phase_next;
      symbol_index  <= symbol_index_next;
      element_index <= element_index_next;
      tick_count    <= tick_count_next;
    end
  end

  assign stat.mark   = (phase_next == PH_MARK);
  assign stat.active = (phase_next != PH_IDLE);

endmodule

// File: src/morse_beeper_sequencer.sv
// Morse beeper sequencer: input stream of ticks, character writes and stops,
// one status result per item. Depends on mbs_pkg, mbs_front, mbs_symq, mbs_seq.
//
// Usage:
//   s_axis carries one item per transaction: tuser holds the operation
//   (tick, write character, stop), tdata the character code. Every accepted
//   item produces exactly one result on m_axis: beeper on, busy, and a flag
//   for a write dropped on a full character queue.
//   The dot length is written through cfg_we/cfg_wdata while the stream is idle.
// Timing:
//   An item is fully processed in the cycle it is accepted; its result is
//   registered into the output buffer. One item per cycle is sustained while
//   the output buffer has room (s_axis_tready high).
// Reset:
//   rst empties the queue, sends the sequencer idle and sets the dot length
//   to 50 ticks. There is no clearing pass; input is taken right after reset.
// Backpressure:
//   results wait in a two-entry output buffer; s_axis_tready is low while both
//   entries are held, which only follows a cycle with m_axis_tready low.
module morse_beeper_sequencer
  import mbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] char_code
  input  logic [1:0]       s_axis_tuser,   // [1:0] op
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] beeper_on, [1] busy_res, [2] overflow
  input  logic             cfg_we,
  input  logic [DOT_W-1:0] cfg_wdata
);

  front_ctl_t ctl;
  q_stat_t    qstat;
  seq_stat_t  sstat;
  logic       accept, overflow, fetch, q_busy, pop;
  logic [2:0] result;
  logic [2:0] res0, res1;
  logic       v0, v1;

  assign accept = s_axis_tvalid && s_axis_tready;

  mbs_front u_front (
    .accept    (accept),
    .op        (s_axis_tuser),
    .char_code (s_axis_tdata),
    .full      (qstat.full),
    .ctl       (ctl),
    .overflow  (overflow)
  );

  mbs_symq u_symq (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .fetch     (fetch),
    .stat      (qstat),
    .busy_next (q_busy)
  );

  mbs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .qstat     (qstat),
    .fetch     (fetch),
    .stat      (sstat)
  );

  assign result = {overflow, q_busy || sstat.active, sstat.mark};
  assign pop    = v0 && m_axis_tready;

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop) begin
      if (v1) begin
        v1 <= 1'b0;
      end else if (!accept) begin
        v0 <= 1'b0;
      end
    end else if (accept) begin
      if (!v0) begin
        v0 <= 1'b1;
      end else begin
        v1 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (v1) begin
        res0 <= res1;
      end else if (accept) begin
        res0 <= result;
      end
    end else if (accept) begin
      if (!v0) begin
        res0 <= result;
      end else begin
        res1 <= result;
      end
    end
  end

  assign s_axis_tready = !v1;
  assign m_axis_tvalid = v0;
  assign m_axis_tdata  = {5'b00000, res0};

endmodule

// File: src/mbs_checker.sv
// port-level checks for morse_beeper_sequencer, bound to the top level
// depends only on the top-level ports
module mbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // output buffer is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("outputs not cleared by reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a sounding beeper means work in progress
  a_beep_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("beeper on while not busy");

  // a dropped write needs a full queue, so the block is busy
  a_ovf_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("overflow while not busy");

  // skid entry is only used after a stall
  a_skid: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid) && !$past(m_axis_tready))
    else $error("input stalled without output stall");

endmodule

bind morse_beeper_sequencer mbs_checker u_mbs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
